// ===== hw/rtl/lgp_pkg.sv =====
package lgp_pkg;

	localparam int CW    = 20;   // coordinate field width
	localparam int RELW  = 21;   // coordinate difference width
	localparam int DR2W  = 42;   // squared segment length width
	localparam int FW    = 24;   // perpendicular foot coordinate width
	localparam int QF    = 23;   // quotient bits of the foot division
	localparam int NUMW1 = 64;   // numerator width of the foot division

	localparam logic [15:0] RADIUS_RESET = 16'd3840;
	localparam logic signed [CW-1:0] FIELD_MAX = 20'sh7FFFF;
	localparam logic signed [CW-1:0] FIELD_MIN = 20'sh80000;

	typedef struct packed {
		logic signed [CW-1:0]   px;
		logic signed [CW-1:0]   py;
		logic signed [RELW-1:0] x1;
		logic signed [RELW-1:0] y1;
		logic signed [RELW-1:0] x2;
		logic signed [RELW-1:0] y2;
		logic signed [RELW-1:0] dx;
		logic signed [RELW-1:0] dy;
		logic [RELW-1:0]        adx;
		logic [RELW-1:0]        ady;
		logic [DR2W-1:0]        dr2;
		logic                   fxneg;
		logic                   fyneg;
		logic signed [FW-1:0]   fx;
		logic signed [FW-1:0]   fy;
		logic                   hneg;
	} side_t;

endpackage

// ===== hw/rtl/lgp_div.sv =====
module lgp_div #(
	parameter int NW = 64,
	parameter int DW = 43,
	parameter int QW = 23
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int EW = NW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [NW-1:0] rem_n [QW];
	logic [DW-1:0] den_n [QW];
	logic [QW-1:0] quo_n [QW];

	// one quotient bit per stage, most significant first
	always_comb begin
		logic [NW-1:0] r;
		logic [DW-1:0] d;
		logic [QW-1:0] q;
		logic [EW-1:0] t;
		for (int j = 0; j < QW; j++) begin
			if (j == 0) begin
				r = num;
				d = den;
				q = '0;
			end else begin
				r = rem_s[j-1];
				d = den_s[j-1];
				q = quo_s[j-1];
			end
			t = EW'(d) << (QW - 1 - j);
			if (EW'(r) >= t) begin
				rem_n[j] = NW'(EW'(r) - t);
				quo_n[j] = q | (QW'(1) << (QW - 1 - j));
			end else begin
				rem_n[j] = r;
				quo_n[j] = q;
			end
			den_n[j] = d;
		end
	end

	always_ff @(posedge clk) begin
		rem_s <= rem_n;
		den_s <= den_n;
		quo_s <= quo_n;
	end

	assign quo = quo_s[QW-1];

endmodule

// ===== hw/rtl/lgp_sqrt.sv =====
module lgp_sqrt #(
	parameter int OW = 21
) (
	input  logic            clk,
	input  logic [2*OW-1:0] val,
	output logic [OW-1:0]   root
);

	localparam int IW = 2 * OW;
	localparam int EW = IW + 2;

	logic [IW-1:0] rem_s [OW];
	logic [OW-1:0] res_s [OW];
	logic [IW-1:0] rem_n [OW];
	logic [OW-1:0] res_n [OW];

	// rem holds val - res^2; try one root bit per stage
	always_comb begin
		logic [IW-1:0] r;
		logic [OW-1:0] q;
		logic [EW-1:0] t;
		for (int j = 0; j < OW; j++) begin
			if (j == 0) begin
				r = val;
				q = '0;
			end else begin
				r = rem_s[j-1];
				q = res_s[j-1];
			end
			t = (EW'(q) << (OW - j)) + (EW'(1) << (2 * (OW - 1 - j)));
			if (EW'(r) >= t) begin
				rem_n[j] = IW'(EW'(r) - t);
				res_n[j] = q | (OW'(1) << (OW - 1 - j));
			end else begin
				rem_n[j] = r;
				res_n[j] = q;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_s <= rem_n;
		res_s <= res_n;
	end

	assign root = res_s[OW-1];

endmodule

// ===== hw/rtl/lookahead_goal_point.sv =====
// Lookahead goal point: intersects the lookahead circle around the robot
// position with one path segment and returns the goal point on it.
// Input: pulse start with pos, segment start and segment end; busy stays low,
// so a new item can be given in every cycle.
// Output: done is high for one cycle with goal_x, goal_y and found. With no
// hit on the segment, goal is the segment start and found is low.
// Items pass the front stages, the foot division, the square roots, the offset
// division and the output stages in that order; throughput is one item per
// cycle. The internal radius is 16 bits wide for FRACTION_BITS <= 8, else
// 8 + FRACTION_BITS. The user must write the radius register (cfg_we /
// cfg_wdata) between items only; the block itself does not enforce it.
// Reset clears all valid bits and loads the radius with 15.0 inches.
// The receiver cannot stall: each result is shown once and must be taken.
module lookahead_goal_point #(
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] start_x,
	input  logic signed [19:0] start_y,
	input  logic signed [19:0] end_x,
	input  logic signed [19:0] end_y,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic signed [19:0] goal_x,
	output logic signed [19:0] goal_y,
	output logic        found
);

	localparam int CW    = lgp_pkg::CW;
	localparam int RELW  = lgp_pkg::RELW;
	localparam int FW    = lgp_pkg::FW;
	localparam int QF    = lgp_pkg::QF;
	localparam int RW    = (FRACTION_BITS > 8) ? 8 + FRACTION_BITS : 16;
	localparam int SW    = (RW > 21) ? RW : 21;
	localparam int QW2   = RW + 2;
	localparam int OXW   = RW + 3;
	localparam int AW    = ((OXW > FW) ? OXW : FW) + 1;
	localparam int DW    = AW + 1;
	localparam int MW    = RELW + SW;
	localparam int NUMW2 = MW + 2;
	localparam int H2W   = ((SW > FW) ? 2 * SW : 2 * FW) + 2;
	localparam int GW    = AW + 1;
	localparam int LAT   = 18 + QF + SW + QW2;

	logic [15:0]   radius_q;
	logic [RW-1:0] r_c;

	// front: differences, products, numerators of the foot division
	lgp_pkg::side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;
	lgp_pkg::side_t sd1_c, sd3_c, sd4_c;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [2*RELW-1:0] pxx_s2, pyy_s2, pa_s2, pb_s2;
	logic signed [2*RELW:0]   dd_s3;
	logic [2*RELW-1:0]        add_s4;
	logic [2*RELW-1:0]        plx_s5, phx_s5, ply_s5, phy_s5;
	logic [3*RELW-1:0]        nx_s6, ny_s6;
	logic [lgp_pkg::NUMW1-1:0] numx_s7, numy_s7;
	logic [lgp_pkg::DR2W:0]    den_s7;

	// foot division
	lgp_pkg::side_t sd_d1 [QF];
	logic [QF-1:0]  vd1_q;
	logic [QF-1:0]  qfx, qfy;

	// foot, h2, square roots
	lgp_pkg::side_t sd_c1, sd_c2, sd_c3;
	lgp_pkg::side_t sdc1_c, sdc3_c;
	logic v_c1, v_c2, v_c3;
	logic signed [2*FW-1:0] fx2_c2, fy2_c2;
	logic [2*RW-1:0]        r2_c2;
	logic signed [H2W-1:0]  h2_c;
	logic [2*SW-1:0]        sqh_c3, sqd_c3;
	lgp_pkg::side_t sd_q [SW];
	logic [SW-1:0]  vq_q;
	logic [SW-1:0]  hq, dq;

	// offset division
	lgp_pkg::side_t sd_e1, sd_e2;
	logic v_e1, v_e2;
	logic [MW-1:0]    mx_e1, my_e1;
	logic [SW-1:0]    dr_e1;
	logic [NUMW2-1:0] numx_e2, numy_e2;
	logic [SW:0]      den_e2;
	lgp_pkg::side_t sd_d2 [QW2];
	logic [QW2-1:0] vd2_q;
	logic [QW2-1:0] qox, qoy;

	// candidates, box test, pick, output
	lgp_pkg::side_t sd_f1, sd_f2, sd_f3, sd_f4, sd_f5;
	logic v_f1, v_f2, v_f3, v_f4, v_f5;
	logic signed [OXW-1:0]  ox_f1, oy_f1;
	logic signed [AW-1:0]   ax_f2, ay_f2, bx_f2, by_f2;
	logic signed [AW-1:0]   ax_f3, ay_f3, bx_f3, by_f3;
	logic signed [DW-1:0]   dax_f3, day_f3, dbx_f3, dby_f3;
	logic                   va_f3, vb_f3, va_f4, vb_f4;
	logic signed [AW-1:0]   ax_f4, ay_f4, bx_f4, by_f4;
	logic signed [2*DW-1:0] sax_f4, say_f4, sbx_f4, sby_f4;
	logic signed [AW-1:0]   gx_f5, gy_f5;
	logic                   found_f5;
	logic signed [GW-1:0]   gsx_c, gsy_c;
	logic signed [CW-1:0]   satx_c, saty_c;
	logic                   done_q, found_q;
	logic signed [CW-1:0]   gx_q, gy_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= lgp_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	generate
		if (FRACTION_BITS >= 8) begin : g_rup
			assign r_c = RW'(radius_q) << (FRACTION_BITS - 8);
		end else begin : g_rdn
			assign r_c = RW'(radius_q >> (8 - FRACTION_BITS));
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
			vd1_q <= '0;
			v_c1 <= 1'b0; v_c2 <= 1'b0; v_c3 <= 1'b0;
			vq_q <= '0;
			v_e1 <= 1'b0; v_e2 <= 1'b0;
			vd2_q <= '0;
			v_f1 <= 1'b0; v_f2 <= 1'b0; v_f3 <= 1'b0; v_f4 <= 1'b0; v_f5 <= 1'b0;
			done_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			vd1_q <= {vd1_q[QF-2:0], v_s7};
			v_c1 <= vd1_q[QF-1]; v_c2 <= v_c1; v_c3 <= v_c2;
			vq_q <= {vq_q[SW-2:0], v_c3};
			v_e1 <= vq_q[SW-1]; v_e2 <= v_e1;
			vd2_q <= {vd2_q[QW2-2:0], v_e2};
			v_f1 <= vd2_q[QW2-1]; v_f2 <= v_f1; v_f3 <= v_f2;
			v_f4 <= v_f3; v_f5 <= v_f4;
			done_q <= v_f5;
			found_q <= v_f5 & found_f5;
		end
	end

	always_comb begin
		sd1_c = '0;
		sd1_c.px = pos_x;
		sd1_c.py = pos_y;
		sd1_c.x1 = RELW'(start_x) - RELW'(pos_x);
		sd1_c.y1 = RELW'(start_y) - RELW'(pos_y);
		sd1_c.x2 = RELW'(end_x) - RELW'(pos_x);
		sd1_c.y2 = RELW'(end_y) - RELW'(pos_y);
		sd1_c.dx = RELW'(end_x) - RELW'(start_x);
		sd1_c.dy = RELW'(end_y) - RELW'(start_y);

		sd3_c = sd_s2;
		sd3_c.dr2 = $unsigned(pxx_s2) + $unsigned(pyy_s2);

		sd4_c = sd_s3;
		sd4_c.adx = sd_s3.dx[RELW-1] ? RELW'(-sd_s3.dx) : RELW'(sd_s3.dx);
		sd4_c.ady = sd_s3.dy[RELW-1] ? RELW'(-sd_s3.dy) : RELW'(sd_s3.dy);
		sd4_c.fxneg = dd_s3[2*RELW] ^ sd_s3.dy[RELW-1];
		sd4_c.fyneg = ~(dd_s3[2*RELW] ^ sd_s3.dx[RELW-1]);
	end

	// front stages
	always_ff @(posedge clk) begin
		sd_s1 <= sd1_c;

		sd_s2 <= sd_s1;
		pxx_s2 <= sd_s1.dx * sd_s1.dx;
		pyy_s2 <= sd_s1.dy * sd_s1.dy;
		pa_s2 <= sd_s1.x1 * sd_s1.y2;
		pb_s2 <= sd_s1.x2 * sd_s1.y1;

		sd_s3 <= sd3_c;
		dd_s3 <= (2*RELW+1)'(pa_s2) - (2*RELW+1)'(pb_s2);

		sd_s4 <= sd4_c;
		add_s4 <= (2*RELW)'(dd_s3[2*RELW] ? -dd_s3 : dd_s3);

		// split |D| in two halves to keep each multiply narrow
		sd_s5 <= sd_s4;
		ply_s5 <= add_s4[RELW-1:0] * sd_s4.ady;
		phy_s5 <= add_s4[2*RELW-1:RELW] * sd_s4.ady;
		plx_s5 <= add_s4[RELW-1:0] * sd_s4.adx;
		phx_s5 <= add_s4[2*RELW-1:RELW] * sd_s4.adx;

		sd_s6 <= sd_s5;
		nx_s6 <= ((3*RELW)'(phy_s5) << RELW) + (3*RELW)'(ply_s5);
		ny_s6 <= ((3*RELW)'(phx_s5) << RELW) + (3*RELW)'(plx_s5);

		// round to nearest: (2n + d) / 2d
		sd_s7 <= sd_s6;
		numx_s7 <= {nx_s6, 1'b0} + lgp_pkg::NUMW1'(sd_s6.dr2);
		numy_s7 <= {ny_s6, 1'b0} + lgp_pkg::NUMW1'(sd_s6.dr2);
		den_s7 <= {sd_s6.dr2, 1'b0};
	end

	lgp_div #(.NW(lgp_pkg::NUMW1), .DW(lgp_pkg::DR2W + 1), .QW(QF)) u_div_fx (
		.clk(clk), .num(numx_s7), .den(den_s7), .quo(qfx)
	);
	lgp_div #(.NW(lgp_pkg::NUMW1), .DW(lgp_pkg::DR2W + 1), .QW(QF)) u_div_fy (
		.clk(clk), .num(numy_s7), .den(den_s7), .quo(qfy)
	);

	always_ff @(posedge clk) begin
		sd_d1[0] <= sd_s7;
		for (int i = 1; i < QF; i++) begin
			sd_d1[i] <= sd_d1[i-1];
		end
	end

	always_comb begin
		h2_c = H2W'($signed({1'b0, r2_c2})) - H2W'(fx2_c2) - H2W'(fy2_c2);

		sdc1_c = sd_d1[QF-1];
		sdc1_c.fx = sd_d1[QF-1].fxneg ? -FW'(qfx) : FW'(qfx);
		sdc1_c.fy = sd_d1[QF-1].fyneg ? -FW'(qfy) : FW'(qfy);

		sdc3_c = sd_c2;
		sdc3_c.hneg = h2_c[H2W-1];
	end

	always_ff @(posedge clk) begin
		sd_c1 <= sdc1_c;

		sd_c2 <= sd_c1;
		fx2_c2 <= sd_c1.fx * sd_c1.fx;
		fy2_c2 <= sd_c1.fy * sd_c1.fy;
		r2_c2 <= r_c * r_c;

		// a negative h2 means the circle misses the line: take the root of zero
		sd_c3 <= sdc3_c;
		sqh_c3 <= h2_c[H2W-1] ? '0 : h2_c[2*SW-1:0];
		sqd_c3 <= (2*SW)'(sd_c2.dr2);
	end

	lgp_sqrt #(.OW(SW)) u_sqrt_h (.clk(clk), .val(sqh_c3), .root(hq));
	lgp_sqrt #(.OW(SW)) u_sqrt_d (.clk(clk), .val(sqd_c3), .root(dq));

	always_ff @(posedge clk) begin
		sd_q[0] <= sd_c3;
		for (int i = 1; i < SW; i++) begin
			sd_q[i] <= sd_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		sd_e1 <= sd_q[SW-1];
		mx_e1 <= sd_q[SW-1].adx * hq;
		my_e1 <= sd_q[SW-1].ady * hq;
		dr_e1 <= dq;

		sd_e2 <= sd_e1;
		numx_e2 <= {mx_e1, 1'b0} + NUMW2'(dr_e1);
		numy_e2 <= {my_e1, 1'b0} + NUMW2'(dr_e1);
		den_e2 <= {dr_e1, 1'b0};
	end

	lgp_div #(.NW(NUMW2), .DW(SW + 1), .QW(QW2)) u_div_ox (
		.clk(clk), .num(numx_e2), .den(den_e2), .quo(qox)
	);
	lgp_div #(.NW(NUMW2), .DW(SW + 1), .QW(QW2)) u_div_oy (
		.clk(clk), .num(numy_e2), .den(den_e2), .quo(qoy)
	);

	always_ff @(posedge clk) begin
		sd_d2[0] <= sd_e2;
		for (int i = 1; i < QW2; i++) begin
			sd_d2[i] <= sd_d2[i-1];
		end
	end

	always_ff @(posedge clk) begin
		// x offset carries sgn(dy) * dx; y offset is never negative
		sd_f1 <= sd_d2[QW2-1];
		ox_f1 <= (sd_d2[QW2-1].dx[RELW-1] ^ sd_d2[QW2-1].dy[RELW-1]) ?
			-OXW'(qox) : OXW'(qox);
		oy_f1 <= OXW'(qoy);

		sd_f2 <= sd_f1;
		ax_f2 <= AW'(sd_f1.fx) + AW'(ox_f1);
		ay_f2 <= AW'(sd_f1.fy) + AW'(oy_f1);
		bx_f2 <= AW'(sd_f1.fx) - AW'(ox_f1);
		by_f2 <= AW'(sd_f1.fy) - AW'(oy_f1);

		sd_f3 <= sd_f2;
		ax_f3 <= ax_f2; ay_f3 <= ay_f2; bx_f3 <= bx_f2; by_f3 <= by_f2;
		va_f3 <= AW'((sd_f2.x1 < sd_f2.x2) ? sd_f2.x1 : sd_f2.x2) <= ax_f2 &&
			ax_f2 <= AW'((sd_f2.x1 > sd_f2.x2) ? sd_f2.x1 : sd_f2.x2) &&
			AW'((sd_f2.y1 < sd_f2.y2) ? sd_f2.y1 : sd_f2.y2) <= ay_f2 &&
			ay_f2 <= AW'((sd_f2.y1 > sd_f2.y2) ? sd_f2.y1 : sd_f2.y2);
		vb_f3 <= AW'((sd_f2.x1 < sd_f2.x2) ? sd_f2.x1 : sd_f2.x2) <= bx_f2 &&
			bx_f2 <= AW'((sd_f2.x1 > sd_f2.x2) ? sd_f2.x1 : sd_f2.x2) &&
			AW'((sd_f2.y1 < sd_f2.y2) ? sd_f2.y1 : sd_f2.y2) <= by_f2 &&
			by_f2 <= AW'((sd_f2.y1 > sd_f2.y2) ? sd_f2.y1 : sd_f2.y2);
		dax_f3 <= DW'(sd_f2.x2) - DW'(ax_f2);
		day_f3 <= DW'(sd_f2.y2) - DW'(ay_f2);
		dbx_f3 <= DW'(sd_f2.x2) - DW'(bx_f2);
		dby_f3 <= DW'(sd_f2.y2) - DW'(by_f2);

		sd_f4 <= sd_f3;
		ax_f4 <= ax_f3; ay_f4 <= ay_f3; bx_f4 <= bx_f3; by_f4 <= by_f3;
		va_f4 <= va_f3; vb_f4 <= vb_f3;
		sax_f4 <= dax_f3 * dax_f3;
		say_f4 <= day_f3 * day_f3;
		sbx_f4 <= dbx_f3 * dbx_f3;
		sby_f4 <= dby_f3 * dby_f3;

		// with both points on the segment, take the first only if it is strictly nearer the segment end
		sd_f5 <= sd_f4;
		found_f5 <= (sd_f4.dr2 != '0) && !sd_f4.hneg && (va_f4 || vb_f4);
		if ((sd_f4.dr2 == '0) || sd_f4.hneg || !(va_f4 || vb_f4)) begin
			gx_f5 <= AW'(sd_f4.x1);
			gy_f5 <= AW'(sd_f4.y1);
		end else if (va_f4 && (!vb_f4 ||
				((2*DW+1)'(sax_f4) + (2*DW+1)'(say_f4)) <
				((2*DW+1)'(sbx_f4) + (2*DW+1)'(sby_f4)))) begin
			gx_f5 <= ax_f4;
			gy_f5 <= ay_f4;
		end else begin
			gx_f5 <= bx_f4;
			gy_f5 <= by_f4;
		end

		gx_q <= satx_c;
		gy_q <= saty_c;
	end

	// back to the field frame, clamp to the field range
	always_comb begin
		gsx_c = GW'(sd_f5.px) + GW'(gx_f5);
		gsy_c = GW'(sd_f5.py) + GW'(gy_f5);
		if (gsx_c > GW'(lgp_pkg::FIELD_MAX)) begin
			satx_c = lgp_pkg::FIELD_MAX;
		end else if (gsx_c < GW'(lgp_pkg::FIELD_MIN)) begin
			satx_c = lgp_pkg::FIELD_MIN;
		end else begin
			satx_c = gsx_c[CW-1:0];
		end
		if (gsy_c > GW'(lgp_pkg::FIELD_MAX)) begin
			saty_c = lgp_pkg::FIELD_MAX;
		end else if (gsy_c < GW'(lgp_pkg::FIELD_MIN)) begin
			saty_c = lgp_pkg::FIELD_MIN;
		end else begin
			saty_c = gsy_c[CW-1:0];
		end
	end

	assign done   = done_q;
	assign found  = found_q;
	assign goal_x = gx_q;
	assign goal_y = gy_q;

	a_found_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> done)
		else $error("found without done");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("item did not come out after the pipeline latency");

	a_miss_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (goal_x == $past(start_x, LAT) &&
		goal_y == $past(start_y, LAT)))
		else $error("miss did not return the segment start");

	a_miss_circle: assert property (@(posedge clk) disable iff (!arst_n)
		(v_f5 && sd_f5.hneg) |=> !found)
		else $error("found set although the circle misses the line");

endmodule

// ===== sim/lookahead_goal_point_test.sv =====
module lookahead_goal_point_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 80;
	localparam int N_RANDOM = 1850;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [19:0] gx;
		logic signed [19:0] gy;
		logic               hit;
	} goal_t;

	typedef struct {
		logic signed [19:0] px, py, sx, sy, ex, ey;
		logic               known;
		logic signed [19:0] gx, gy;
		logic               hit;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [19:0] pos_x = '0, pos_y = '0, start_x = '0, start_y = '0;
	logic signed [19:0] end_x = '0, end_y = '0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic done;
	logic signed [19:0] goal_x, goal_y;
	logic found;

	lookahead_goal_point u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .goal_x(goal_x), .goal_y(goal_y), .found(found)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [15:0] radius_q88 = lgp_pkg::RADIUS_RESET;
	goal_t goals_due[$];
	int errors = 0;
	longint cycles = 0;

	task automatic report(input string what);
		errors++;
		$display("ERROR @%0t: %s", $realtime, what);
	endtask

	function automatic longint root_floor(input longint v);
		longint lo, hi, mid;
		lo = 0;
		hi = 32'hFFFFFFFF;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint div_nearest(input longint n, input longint d);
		longint m, q;
		m = (n < 0) ? -n : n;
		q = (2 * m + d) / (2 * d);
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic signed [19:0] clamp20(input longint v);
		if (v > 524287) return lgp_pkg::FIELD_MAX;
		if (v < -524288) return lgp_pkg::FIELD_MIN;
		return v[19:0];
	endfunction

	function automatic goal_t intersect_segment(input longint px, py, sx, sy, ex, ey);
		goal_t g;
		longint x1, y1, x2, y2, dx, dy, dr2, dd, fx, fy, h2, h, dr, r;
		longint ox, oy, ax, ay, bx, by, lox, hix, loy, hiy, sdx, ady, gx, gy;
		bit va, vb, pick_a, hit;
		x1 = sx - px; y1 = sy - py; x2 = ex - px; y2 = ey - py;
		dx = x2 - x1; dy = y2 - y1;
		dr2 = dx * dx + dy * dy;
		gx = sx; gy = sy; hit = 0;
		if (dr2 != 0) begin
			r = longint'(radius_q88);
			dd = x1 * y2 - x2 * y1;
			fx = div_nearest(dd * dy, dr2);
			fy = div_nearest(-(dd * dx), dr2);
			h2 = r * r - (fx * fx + fy * fy);
			if (h2 >= 0) begin
				h = root_floor(h2);
				dr = root_floor(dr2);
				sdx = (dy >= 0) ? dx : -dx;
				ady = (dy >= 0) ? dy : -dy;
				ox = div_nearest(sdx * h, dr);
				oy = div_nearest(ady * h, dr);
				ax = fx + ox; ay = fy + oy; bx = fx - ox; by = fy - oy;
				lox = (x1 < x2) ? x1 : x2; hix = (x1 < x2) ? x2 : x1;
				loy = (y1 < y2) ? y1 : y2; hiy = (y1 < y2) ? y2 : y1;
				va = lox <= ax && ax <= hix && loy <= ay && ay <= hiy;
				vb = lox <= bx && bx <= hix && loy <= by && by <= hiy;
				pick_a = 0;
				if (va && vb)
					pick_a = ((x2-ax)*(x2-ax) + (y2-ay)*(y2-ay)) <
						((x2-bx)*(x2-bx) + (y2-by)*(y2-by));
				else if (va)
					pick_a = 1;
				if (va || vb) begin
					hit = 1;
					gx = (pick_a ? ax : bx) + px;
					gy = (pick_a ? ay : by) + py;
				end
			end
		end
		g.gx = clamp20(gx);
		g.gy = clamp20(gy);
		g.hit = hit;
		return g;
	endfunction

	// check every result against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (goals_due.size() == 0)
				report("result with nothing expected");
			else begin
				goal_t g;
				g = goals_due.pop_front();
				if (goal_x !== g.gx) report($sformatf("goal_x %0d exp %0d", goal_x, g.gx));
				if (goal_y !== g.gy) report($sformatf("goal_y %0d exp %0d", goal_y, g.gy));
				if (found !== g.hit) report($sformatf("found %0b exp %0b", found, g.hit));
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("lookahead_goal_point regression: fail");
			$finish;
		end
	end

	int gap_left = 0, burst_left = 0;

	task automatic send_item(input row_t it);
		goal_t g;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		end
		while (gap_left > 0) begin
			start <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		burst_left--;
		start <= 1'b1;
		pos_x <= it.px; pos_y <= it.py; start_x <= it.sx; start_y <= it.sy;
		end_x <= it.ex; end_y <= it.ey;
		g = intersect_segment(it.px, it.py, it.sx, it.sy, it.ex, it.ey);
		if (it.known && (g.gx !== it.gx || g.gy !== it.gy || g.hit !== it.hit))
			report("directed row disagrees with predictor");
		if (it.known) begin
			g.gx = it.gx; g.gy = it.gy; g.hit = it.hit;
		end
		@(posedge clk);
		while (busy) @(posedge clk);
		goals_due.push_back(g);
	endtask

	task automatic drain_and_configure(input logic [15:0] r);
		start <= 1'b0;
		@(posedge clk);
		while (goals_due.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_q88 = r;
	endtask

	function automatic logic signed [19:0] rand_coord(input int span);
		case ($urandom_range(0, 9))
			0: return lgp_pkg::FIELD_MAX;
			1: return lgp_pkg::FIELD_MIN;
			2: return 20'($urandom());
			default: return 20'($signed(20'($urandom_range(0, 2 * span))) - span);
		endcase
	endfunction

	// make a segment that crosses the circle most of the time
	function automatic row_t rand_row();
		row_t it;
		int span, rr;
		span = (radius_q88 == 0) ? 256 : radius_q88 * 3;
		if (span > 200000) span = 200000;
		it.known = 0;
		it.px = rand_coord(4000);
		it.py = rand_coord(4000);
		rr = $urandom_range(0, 3);
		if (rr == 0) begin
			it.sx = 20'($urandom()); it.sy = 20'($urandom());
			it.ex = 20'($urandom()); it.ey = 20'($urandom());
		end else begin
			it.sx = clamp20(longint'(it.px) + $signed(20'($urandom_range(0, 2*span))) - span);
			it.sy = clamp20(longint'(it.py) + $signed(20'($urandom_range(0, 2*span))) - span);
			it.ex = clamp20(longint'(it.px) + $signed(20'($urandom_range(0, 2*span))) - span);
			it.ey = clamp20(longint'(it.py) + $signed(20'($urandom_range(0, 2*span))) - span);
			if (rr == 1) it.ex = it.sx;
		end
		return it;
	endfunction

	row_t plan[$];
	logic [15:0] radii[6] = '{16'd3840, 16'hFFFF, 16'd0, 16'd256, 16'd1, 16'd30000};

	initial begin
		plan.push_back('{0, 0, 0, 0, 0, 0, 1, 0, 0, 0});
		plan.push_back('{0, 0, 100, 100, 100, 100, 1, 100, 100, 0});
		plan.push_back('{0, 0, -7680, 0, 7680, 0, 1, 3840, 0, 1});
		plan.push_back('{0, 0, 7680, 0, -7680, 0, 1, -3840, 0, 1});
		plan.push_back('{0, 0, 0, -7680, 0, 7680, 1, 0, 3840, 1});
		plan.push_back('{0, 0, -7680, 3840, 7680, 3840, 1, 0, 3840, 1});
		plan.push_back('{0, 0, -7680, 5000, 7680, 5000, 1, -7680, 5000, 0});
		plan.push_back('{0, 0, 0, 0, 1000, 0, 1, 0, 0, 0});
		plan.push_back('{0, 0, 0, 0, 3840, 0, 1, 3840, 0, 1});
		plan.push_back('{lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX,
			lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MIN,
			lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX, 0, 0, 0, 0});
		plan.push_back('{lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MIN,
			lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX,
			lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MIN, 0, 0, 0, 0});
		plan.push_back('{lgp_pkg::FIELD_MIN, 0, lgp_pkg::FIELD_MAX, 5,
			lgp_pkg::FIELD_MIN, -5, 0, 0, 0, 0});
		plan.push_back('{lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MIN,
			lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MIN,
			lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX, 0, 0, 0, 0});
		plan.push_back('{-20'sd1, -20'sd1, -3000, -4000, 3000, 4000, 0, 0, 0, 0});
		plan.push_back('{0, 0, -5000, 1, 5000, -1, 0, 0, 0, 0});
		plan.push_back('{lgp_pkg::FIELD_MAX, 0, lgp_pkg::FIELD_MAX, -3840,
			lgp_pkg::FIELD_MAX, 3840, 0, 0, 0, 0});
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) send_item(plan[i]);
		// saturation: huge radius near the field edge
		drain_and_configure(16'hFFFF);
		send_item('{lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX,
			lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MAX, lgp_pkg::FIELD_MAX, 0, 0, 0, 0});
		send_item('{lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MIN,
			lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MIN, lgp_pkg::FIELD_MAX, 0, 0, 0, 0});
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_configure((ph == 5) ? 16'($urandom()) : radii[ph]);
			for (int n = 0; n < N_RANDOM / 6; n++) send_item(rand_row());
		end
		start <= 1'b0;
		@(posedge clk);
		while (goals_due.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("lookahead_goal_point regression: pass");
		else
			$display("lookahead_goal_point regression: fail");
		$finish;
	end
endmodule
